[src/wgm_pkg.sv]
`timescale 1ns / 1ps

package wgm_pkg;

	localparam int MAX_PATTERN_DEF = 32;
	localparam int CFG_DATA_W      = 64;
	localparam int CFG_INDEX_W     = 3;
	localparam int LEN_REG_W       = 6;

	typedef logic [7:0] char_t;

	localparam char_t STAR_CHAR  = 8'h2A;
	localparam char_t QMARK_CHAR = 8'h3F;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LENGTH,
		REG_BYTES_0_7,
		REG_BYTES_8_15,
		REG_BYTES_16_23,
		REG_BYTES_24_31
	} cfg_reg_t;

endpackage

[src/wgm_intf.sv]
`timescale 1ns / 1ps

interface wgm_subject_if;
	import wgm_pkg::*;

	logic  valid;
	logic  ready;
	char_t subject_char;
	logic  has_char;
	logic  last;

	modport source (output valid, output subject_char, output has_char, output last,
		input ready);
	modport sink (input valid, input subject_char, input has_char, input last,
		output ready);
endinterface

interface wgm_result_if;
	logic valid;
	logic ready;
	logic matched;

	modport source (output valid, output matched, input ready);
	modport sink (input valid, input matched, output ready);
endinterface

[src/wildcard_glob_matcher.sv]
`timescale 1ns / 1ps
// Channel   Role   Word
// subject   in     subject_char, has_char, last
// result    out    matched, one word per subject word with last set
// cfg       in     cfg_en, cfg_index, cfg_data, write only
//
// One subject word per cycle while the result does not stall; a matched word
// follows the last subject word through the input stage and result register.
// The alive-position vector updates through a single carry chain
// across the pattern. Reset clears the pattern and reloads the vector.
// A stalled result holds the input stage only when it holds a last word.

module wildcard_glob_matcher #(
	parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	wgm_subject_if.sink                     subject,
	wgm_result_if.source                    result,
	input  logic                            cfg_en,
	input  logic [wgm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [wgm_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import wgm_pkg::*;

	localparam int VEC_W = MAX_PATTERN + 1;
	localparam int LEN_W = $clog2(MAX_PATTERN + 1);

	logic [LEN_W-1:0]       pat_len;
	char_t                  pat_byte [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] star_mask;
	logic [MAX_PATTERN-1:0] lit_mask;
	logic [MAX_PATTERN-1:0] qmark_mask;
	logic [VEC_W-1:0]       init_vec;
	logic                   reinit;

	wgm_cfg #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pat_len   (pat_len),
		.pat_byte  (pat_byte),
		.star_mask (star_mask),
		.lit_mask  (lit_mask),
		.qmark_mask(qmark_mask),
		.init_vec  (init_vec),
		.reinit    (reinit)
	);

	wgm_core #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.subject   (subject),
		.result    (result),
		.pat_len   (pat_len),
		.pat_byte  (pat_byte),
		.star_mask (star_mask),
		.lit_mask  (lit_mask),
		.qmark_mask(qmark_mask),
		.init_vec  (init_vec),
		.reinit    (reinit)
	);

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!subject.ready |-> (result.valid && !result.ready))
		else $error("subject stalled without a blocked result");

	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(subject.valid && subject.ready && subject.last, 2))
		else $error("result without a last subject word");

	a_star_lit_split: assert property (@(posedge clk) disable iff (!arst_n)
		(star_mask & lit_mask) == '0)
		else $error("pattern position both wildcard and literal");

endmodule

[src/wgm_cfg.sv]
`timescale 1ns / 1ps

module wgm_cfg #(
	parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF,
	localparam int VEC_W = MAX_PATTERN + 1,
	localparam int LEN_W = $clog2(MAX_PATTERN + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_en,
	input  logic [wgm_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [wgm_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic [LEN_W-1:0]                   pat_len,
	output wgm_pkg::char_t                     pat_byte [MAX_PATTERN],
	output logic [MAX_PATTERN-1:0]             star_mask,
	output logic [MAX_PATTERN-1:0]             lit_mask,
	output logic [MAX_PATTERN-1:0]             qmark_mask,
	output logic [VEC_W-1:0]                   init_vec,
	output logic                               reinit
);
	import wgm_pkg::*;

	logic [LEN_REG_W-1:0] len_q;
	char_t                byte_q [MAX_PATTERN];
	logic [VEC_W-1:0]     star_x;
	logic [VEC_W-1:0]     seed;
	logic [VEC_W-1:0]     gen;
	logic [VEC_W-1:0]     sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			for (int k = 0; k < MAX_PATTERN; k++) begin
				byte_q[k] <= '0;
			end
		end else if (cfg_en) begin
			if (cfg_index == REG_LENGTH) begin
				len_q <= cfg_data[LEN_REG_W-1:0];
			end
			for (int k = 0; k < MAX_PATTERN; k++) begin
				if (cfg_index == CFG_INDEX_W'(int'(REG_BYTES_0_7) + k / 8)) begin
					byte_q[k] <= cfg_data[(k % 8) * 8 +: 8];
				end
			end
		end
	end

	assign reinit = cfg_en && (cfg_index <= REG_BYTES_24_31);

	// saturate an overlong length
	assign pat_len = (len_q > LEN_REG_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
		: LEN_W'(len_q);

	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			pat_byte[i]   = byte_q[i];
			star_mask[i]  = (LEN_W'(i) < pat_len) && (byte_q[i] == STAR_CHAR);
			lit_mask[i]   = (LEN_W'(i) < pat_len) && (byte_q[i] != STAR_CHAR);
			qmark_mask[i] = (byte_q[i] == QMARK_CHAR);
		end
	end

	// closure over star runs as a carry chain
	assign star_x   = {1'b0, star_mask};
	assign seed     = VEC_W'(1);
	assign gen      = seed & star_x;
	assign sum      = star_x + gen;
	assign init_vec = seed | (sum ^ star_x ^ gen);

endmodule

[src/wgm_core.sv]
`timescale 1ns / 1ps

module wgm_core #(
	parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF,
	localparam int VEC_W = MAX_PATTERN + 1,
	localparam int LEN_W = $clog2(MAX_PATTERN + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	wgm_subject_if.sink            subject,
	wgm_result_if.source           result,
	input  logic [LEN_W-1:0]       pat_len,
	input  wgm_pkg::char_t         pat_byte [MAX_PATTERN],
	input  logic [MAX_PATTERN-1:0] star_mask,
	input  logic [MAX_PATTERN-1:0] lit_mask,
	input  logic [MAX_PATTERN-1:0] qmark_mask,
	input  logic [VEC_W-1:0]       init_vec,
	input  logic                   reinit
);
	import wgm_pkg::*;

	logic                   valid_s1;
	char_t                  char_s1;
	logic                   has_s1;
	logic                   last_s1;
	logic                   res_valid_q;
	logic                   matched_q;
	logic [VEC_W-1:0]       alive_q;
	logic                   fresh_q;

	logic                   adv;
	logic [VEC_W-1:0]       alive;
	logic [MAX_PATTERN-1:0] hit;
	logic [VEC_W-1:0]       nv;
	logic [VEC_W-1:0]       star_x;
	logic [VEC_W-1:0]       gen;
	logic [VEC_W-1:0]       sum;
	logic [VEC_W-1:0]       closed;
	logic [VEC_W-1:0]       final_vec;

	assign adv           = valid_s1 && (!last_s1 || !res_valid_q || result.ready);
	assign subject.ready = !valid_s1 || adv;
	assign result.valid  = res_valid_q;
	assign result.matched = matched_q;

	assign alive = fresh_q ? init_vec : alive_q;

	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			hit[i] = lit_mask[i] && (qmark_mask[i] || (pat_byte[i] == char_s1));
		end
	end

	assign nv        = ({1'b0, alive[MAX_PATTERN-1:0] & star_mask})
		| {alive[MAX_PATTERN-1:0] & hit, 1'b0};
	assign star_x    = {1'b0, star_mask};
	assign gen       = nv & star_x;
	assign sum       = star_x + gen;
	assign closed    = nv | (sum ^ star_x ^ gen);
	assign final_vec = has_s1 ? closed : alive;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (subject.ready) begin
			valid_s1 <= subject.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (subject.ready && subject.valid) begin
			char_s1 <= subject.subject_char;
			has_s1  <= subject.has_char;
			last_s1 <= subject.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= 1'b1;
			alive_q <= '0;
		end else if (reinit) begin
			fresh_q <= 1'b1;
		end else if (adv) begin
			if (last_s1) begin
				fresh_q <= 1'b1;
			end else if (has_s1) begin
				fresh_q <= 1'b0;
				alive_q <= closed;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			matched_q <= final_vec[pat_len];
		end
	end

endmodule

[verif/wildcard_glob_matcher_tb.sv]
`timescale 1ns / 1ps

module wildcard_glob_matcher_tb;
	import wgm_pkg::*;

	localparam int PAT_MAX = MAX_PATTERN_DEF;
	localparam int RANDOM_WORDS = 600;
	localparam int PHASE_WORDS = 40;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam char_t LOWER_A = 8'h61;

	typedef enum logic [1:0] {
		ROW_WORD,
		ROW_CFG,
		ROW_SETTLE
	} row_kind_t;

	typedef struct {
		row_kind_t               kind;
		logic [CFG_INDEX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0]   data;
		char_t                   ch;
		bit                      has;
		bit                      fin;
		bit                      typed;
		bit                      exp;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	wgm_subject_if subj ();
	wgm_result_if res ();

	wildcard_glob_matcher u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.subject   (subj),
		.result    (res),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	logic [LEN_REG_W-1:0] len_reg;
	logic [63:0] pat_words [4];
	logic [PAT_MAX:0] alive_pos;
	bit expected_matches [$];
	int unsigned mismatches;
	int unsigned words_sent;
	bit steady;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic int unsigned eff_len();
		return (len_reg > PAT_MAX) ? PAT_MAX : len_reg;
	endfunction

	function automatic char_t pat_at(input int unsigned i);
		return pat_words[i[4:3]][(i & 7) * 8 +: 8];
	endfunction

	function automatic logic [PAT_MAX:0] close_stars(input logic [PAT_MAX:0] v);
		int unsigned n;
		n = eff_len();
		for (int unsigned i = 0; i < n; i++) begin
			if (v[i] && pat_at(i) == STAR_CHAR)
				v[i+1] = 1'b1;
		end
		return v;
	endfunction

	task automatic restart_alive();
		alive_pos = close_stars({{PAT_MAX{1'b0}}, 1'b1});
	endtask

	task automatic glob_advance(input char_t ch, input bit has, input bit fin,
		output bit emit, output bit match);
		logic [PAT_MAX:0] nxt;
		int unsigned n;
		n = eff_len();
		emit = 1'b0;
		match = 1'b0;
		if (has) begin
			nxt = '0;
			for (int unsigned i = 0; i < n; i++) begin
				if (alive_pos[i]) begin
					if (pat_at(i) == STAR_CHAR)
						nxt[i] = 1'b1;
					else if (pat_at(i) == QMARK_CHAR || pat_at(i) == ch)
						nxt[i+1] = 1'b1;
				end
			end
			alive_pos = close_stars(nxt);
		end
		if (fin) begin
			emit = 1'b1;
			match = alive_pos[n];
			restart_alive();
		end
	endtask

	function automatic bit idle_now();
		return !steady && ($urandom_range(0, 99) < 14);
	endfunction

	function automatic char_t draw_subject_char();
		case ($urandom_range(0, 9))
			6: return STAR_CHAR;
			7: return QMARK_CHAR;
			8, 9: return char_t'($urandom_range(0, 255));
			default: return LOWER_A + char_t'($urandom_range(0, 2));
		endcase
	endfunction

	function automatic dir_row_t mk(input row_kind_t kind, input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data, input char_t ch, input bit has, input bit fin,
		input bit typed, input bit exp);
		dir_row_t r;
		r.kind = kind;
		r.idx = idx;
		r.data = data;
		r.ch = ch;
		r.has = has;
		r.fin = fin;
		r.typed = typed;
		r.exp = exp;
		return r;
	endfunction

	// entered and left just after a falling edge
	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == REG_LENGTH) begin
			len_reg = data[LEN_REG_W-1:0];
			restart_alive();
		end else if (idx <= REG_BYTES_24_31) begin
			pat_words[2'(idx - REG_BYTES_0_7)] = data;
			restart_alive();
		end
		@(negedge clk);
		cfg_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic push_word(input char_t ch, input bit has, input bit fin,
		input bit typed, input bit typed_exp);
		bit emit;
		bit match;
		while (idle_now()) begin
			subj.valid <= 1'b0;
			subj.subject_char <= char_t'($urandom_range(0, 255));
			subj.has_char <= 1'($urandom_range(0, 1));
			subj.last <= 1'($urandom_range(0, 1));
			@(negedge clk);
		end
		subj.valid <= 1'b1;
		subj.subject_char <= ch;
		subj.has_char <= has;
		subj.last <= fin;
		do @(posedge clk); while (!subj.ready);
		glob_advance(ch, has, fin, emit, match);
		if (emit)
			expected_matches.push_back(typed ? typed_exp : match);
		if (has || fin)
			words_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		subj.valid <= 1'b0;
		while (expected_matches.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	always @(negedge clk)
		res.ready <= !idle_now();

	always @(posedge clk) begin
		bit want;
		if (arst_n && res.valid && res.ready) begin
			if (expected_matches.size() == 0) begin
				$display("%0t: matched expected none, actual %0b", $time, res.matched);
				mismatches++;
			end else begin
				want = expected_matches.pop_front();
				if (res.matched !== want) begin
					$display("%0t: matched expected %0b, actual %0b", $time, want, res.matched);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		dir_row_t rows [$];
		char_t body [$];
		cfg_reg_t byte_regs [4];
		logic [63:0] words [4];
		logic [CFG_DATA_W-1:0] len_data;
		int unsigned len_eff;
		int unsigned phase;
		int unsigned phase_start;
		int unsigned base;
		int unsigned pos;
		bit tail_word;

		byte_regs = '{REG_BYTES_0_7, REG_BYTES_8_15, REG_BYTES_16_23, REG_BYTES_24_31};
		arst_n = 1'b0;
		cfg_en = 1'b0;
		cfg_index = REG_LENGTH;
		cfg_data = '0;
		subj.valid = 1'b0;
		subj.subject_char = '0;
		subj.has_char = 1'b0;
		subj.last = 1'b0;
		res.ready = 1'b1;
		steady = 1'b0;
		mismatches = 0;
		words_sent = 0;
		len_reg = '0;
		foreach (pat_words[w])
			pat_words[w] = '0;
		restart_alive();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		rows.push_back(mk(ROW_WORD, REG_LENGTH, '0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1));
		rows.push_back(mk(ROW_WORD, REG_LENGTH, '0, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0));
		rows.push_back(mk(ROW_WORD, REG_LENGTH, '0, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b0));
		rows.push_back(mk(ROW_SETTLE, REG_LENGTH, '0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
		foreach (byte_regs[r])
			rows.push_back(mk(ROW_CFG, byte_regs[r], {8{STAR_CHAR}}, 8'h00, 1'b0, 1'b0,
				1'b0, 1'b0));
		rows.push_back(mk(ROW_CFG, REG_LENGTH, '1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
		rows.push_back(mk(ROW_WORD, REG_LENGTH, '0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1));
		rows.push_back(mk(ROW_WORD, REG_LENGTH, '0, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1));
		rows.push_back(mk(ROW_WORD, REG_LENGTH, '0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0));
		rows.push_back(mk(ROW_WORD, REG_LENGTH, '0, STAR_CHAR, 1'b1, 1'b1, 1'b1, 1'b1));
		rows.push_back(mk(ROW_SETTLE, REG_LENGTH, '0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
		rows.push_back(mk(ROW_CFG, REG_BYTES_0_7, {40'h0, QMARK_CHAR, STAR_CHAR, LOWER_A},
			8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
		rows.push_back(mk(ROW_CFG, REG_LENGTH, 64'd3, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
		rows.push_back(mk(ROW_WORD, REG_LENGTH, '0, LOWER_A, 1'b1, 1'b0, 1'b0, 1'b0));
		rows.push_back(mk(ROW_WORD, REG_LENGTH, '0, LOWER_A + 8'd1, 1'b1, 1'b1, 1'b0, 1'b0));
		rows.push_back(mk(ROW_WORD, REG_LENGTH, '0, LOWER_A, 1'b1, 1'b1, 1'b0, 1'b0));
		rows.push_back(mk(ROW_WORD, REG_LENGTH, '0, LOWER_A, 1'b1, 1'b0, 1'b0, 1'b0));
		rows.push_back(mk(ROW_WORD, REG_LENGTH, '0, STAR_CHAR, 1'b1, 1'b0, 1'b0, 1'b0));
		rows.push_back(mk(ROW_WORD, REG_LENGTH, '0, 8'h78, 1'b1, 1'b0, 1'b0, 1'b0));
		rows.push_back(mk(ROW_WORD, REG_LENGTH, '0, 8'h79, 1'b1, 1'b1, 1'b0, 1'b0));
		rows.push_back(mk(ROW_WORD, REG_LENGTH, '0, QMARK_CHAR, 1'b1, 1'b0, 1'b0, 1'b0));
		rows.push_back(mk(ROW_WORD, REG_LENGTH, '0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
		rows.push_back(mk(ROW_SETTLE, REG_LENGTH, '0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
		rows.push_back(mk(ROW_CFG, REG_BYTES_0_7, '0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
		rows.push_back(mk(ROW_CFG, REG_LENGTH, 64'd2, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
		rows.push_back(mk(ROW_WORD, REG_LENGTH, '0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0));
		rows.push_back(mk(ROW_WORD, REG_LENGTH, '0, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0));
		// restart a string in progress
		rows.push_back(mk(ROW_WORD, REG_LENGTH, '0, LOWER_A, 1'b1, 1'b0, 1'b0, 1'b0));
		rows.push_back(mk(ROW_SETTLE, REG_LENGTH, '0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
		rows.push_back(mk(ROW_CFG, REG_LENGTH, 64'd1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
		rows.push_back(mk(ROW_WORD, REG_LENGTH, '0, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0));
		// spare index must leave the string alone
		rows.push_back(mk(ROW_WORD, REG_LENGTH, '0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0));
		rows.push_back(mk(ROW_SETTLE, REG_LENGTH, '0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
		rows.push_back(mk(ROW_CFG, REG_SPARE_LO, '1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
		rows.push_back(mk(ROW_WORD, REG_LENGTH, '0, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b0));

		foreach (rows[i]) begin
			case (rows[i].kind)
				ROW_WORD: push_word(rows[i].ch, rows[i].has, rows[i].fin, rows[i].typed,
					rows[i].exp);
				ROW_CFG: cfg_write(rows[i].idx, rows[i].data);
				default: settle();
			endcase
		end

		base = words_sent;
		phase = 0;
		while (words_sent < base + RANDOM_WORDS) begin
			settle();
			len_data = {$urandom, $urandom};
			case (phase)
				0: len_data[LEN_REG_W-1:0] = '0;
				1: len_data[LEN_REG_W-1:0] = LEN_REG_W'(PAT_MAX);
				2: len_data[LEN_REG_W-1:0] = '1;
				default: begin
					case ($urandom_range(0, 9))
						0: len_data[LEN_REG_W-1:0] = '0;
						1: len_data[LEN_REG_W-1:0] = LEN_REG_W'(PAT_MAX);
						2: len_data[LEN_REG_W-1:0] =
							LEN_REG_W'($urandom_range(PAT_MAX + 1, 63));
						default: len_data[LEN_REG_W-1:0] = LEN_REG_W'($urandom_range(1, 10));
					endcase
				end
			endcase
			len_eff = (len_data[LEN_REG_W-1:0] > PAT_MAX) ? PAT_MAX : len_data[LEN_REG_W-1:0];
			for (int unsigned b = 0; b < PAT_MAX; b++) begin
				if (b >= len_eff)
					words[b[4:3]][(b & 7) * 8 +: 8] = char_t'($urandom_range(0, 255));
				else if (phase == 1)
					words[b[4:3]][(b & 7) * 8 +: 8] = QMARK_CHAR;
				else begin
					case ($urandom_range(0, 9))
						0, 1: words[b[4:3]][(b & 7) * 8 +: 8] = STAR_CHAR;
						2: words[b[4:3]][(b & 7) * 8 +: 8] = QMARK_CHAR;
						9: words[b[4:3]][(b & 7) * 8 +: 8] = char_t'($urandom_range(0, 255));
						default: words[b[4:3]][(b & 7) * 8 +: 8] =
							LOWER_A + char_t'($urandom_range(0, 2));
					endcase
				end
			end
			if ($urandom_range(0, 3) == 0)
				cfg_write(CFG_INDEX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
					{$urandom, $urandom});
			foreach (byte_regs[r])
				cfg_write(byte_regs[r], words[r]);
			cfg_write(REG_LENGTH, len_data);

			steady = (phase >= 6 && phase < 9);
			phase_start = words_sent;
			while (words_sent < phase_start + PHASE_WORDS && words_sent < base + RANDOM_WORDS) begin
				body.delete();
				if ($urandom_range(0, 9) == 0) begin
					repeat ($urandom_range(0, 8))
						body.push_back(draw_subject_char());
				end else begin
					for (int unsigned i = 0; i < len_eff; i++) begin
						case (pat_at(i))
							STAR_CHAR: repeat ($urandom_range(0, 3))
								body.push_back(draw_subject_char());
							QMARK_CHAR: body.push_back(draw_subject_char());
							default: body.push_back(pat_at(i));
						endcase
					end
					// break a well-formed string now and then
					if ($urandom_range(0, 3) == 0) begin
						pos = $urandom_range(0, body.size());
						case ($urandom_range(0, 2))
							0: if (pos < body.size()) body[pos] = draw_subject_char();
							1: if (pos < body.size()) body.delete(pos);
							default: body.insert(pos, draw_subject_char());
						endcase
					end
				end
				tail_word = (body.size() == 0) || ($urandom_range(0, 1) == 1);
				foreach (body[j]) begin
					if ($urandom_range(0, 9) == 0)
						push_word(draw_subject_char(), 1'b0, 1'b0, 1'b0, 1'b0);
					push_word(body[j], 1'b1, !tail_word && (j == int'(body.size()) - 1),
						1'b0, 1'b0);
				end
				if (tail_word)
					push_word(draw_subject_char(), 1'b0, 1'b1, 1'b0, 1'b0);
			end
			phase++;
		end

		steady = 1'b0;
		settle();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
